// ===== hdl/amp_pkg.sv =====
// Shared types, constants and register codes for the adaptive-moment update engine.
package amp_pkg;

    localparam int ELEMENTS = 4096;
    localparam int ELEM_AW  = $clog2(ELEMENTS);

    localparam logic [24:0] ONE_Q24       = 25'd16777216;
    localparam logic [23:0] VAR_DECAY_Q24 = 24'd15099494;
    localparam logic [20:0] VAR_GAIN_Q24  = 21'd1677722;
    localparam logic [63:0] EPS_Q24       = 64'd168;
    localparam logic [26:0] CLIP_Q24      = 27'd67108864;

    localparam logic [23:0] RST_MOMENTUM_DECAY = 24'd15099494;
    localparam logic [23:0] RST_EXTRA_RATE     = 24'd16777;
    localparam logic [23:0] RST_FINAL_RATE     = 24'd0;
    localparam logic [23:0] RST_RATE_DECAY     = 24'hFFFFFF;

    // square root: 64-bit radicand, 32-bit root, SQ_STEP root bits per stage
    localparam int SQ_XW     = 64;
    localparam int SQ_RW     = 32;
    localparam int SQ_STEP   = 2;
    localparam int SQ_STAGES = SQ_RW / SQ_STEP;

    // restoring divider: DIV_STEP quotient bits per stage
    localparam int DIV_W      = 64;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = DIV_W / DIV_STEP;

    typedef enum logic [1:0] {
        REG_MOMENTUM_DECAY = 2'd0,
        REG_INITIAL_EXTRA  = 2'd1,
        REG_FINAL_RATE     = 2'd2,
        REG_RATE_DECAY     = 2'd3
    } reg_idx_t;

    // per-item data that rides along the math pipeline
    typedef struct packed {
        logic signed [31:0] param;
        logic [24:0]        rate;
        logic signed [31:0] mom;
        logic               den_zero;
    } side_t;

    typedef struct packed {
        logic clearing;
        logic hazard;
    } mom_stat_t;

endpackage

// ===== hdl/adaptive_moment_param_update_top.sv =====
// Adaptive-moment parameter update engine: config port, pass schedule and step datapath.
// Pipeline: 88 register stages (4 store update, 16 root, 32 + 32 divider stages,
//   4 glue/output stages). Throughput: one transfer per cycle while the output skid
//   entry is empty and no index hazard holds an input off.
// An input is held off while an earlier item with the same element_index sits in the
//   3-stage store read-modify-write window; distinct indexes stream at full rate.
// After rst_n all 4096 moment store entries are cleared; s_tready stays low
//   until done. Config registers and schedule state reset to their defaults.
module adaptive_moment_param_update_top (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // [11:0] element_index, [43:12] gradient,
                                   // [75:44] param_value, [79:76] zero
    input  logic [0:0]  s_tuser,   // [0] pass_start
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] new_param
    output logic [0:0]  m_tuser,   // [0] step_clipped
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import amp_pkg::*;

    // ---------------- config registers ----------------
    logic [23:0] md_reg;       // momentum decay
    logic [23:0] iextra_reg;   // initial extra rate
    logic [23:0] final_reg;    // final rate
    logic [23:0] rdf_reg;      // rate decay factor
    // pass schedule state
    logic [23:0] extra_reg;
    logic [24:0] vbp_reg;      // second-moment bias product, Q1.24
    logic [24:0] prate_reg;    // rate latched at the last pass start

    reg_idx_t    cfg_idx;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        unique case (cfg_idx)
            REG_MOMENTUM_DECAY: prdata = {8'b0, md_reg};
            REG_INITIAL_EXTRA:  prdata = {8'b0, iextra_reg};
            REG_FINAL_RATE:     prdata = {8'b0, final_reg};
            REG_RATE_DECAY:     prdata = {8'b0, rdf_reg};
            default:            prdata = '0;
        endcase
    end

    // ---------------- input side ----------------
    logic                     adv;        // whole pipeline moves this cycle
    logic                     acc;
    logic [ELEM_AW-1:0]       in_idx;
    logic signed [31:0]       in_grad;
    logic signed [31:0]       in_param;
    logic                     in_start;
    logic [24:0]              rate_start;
    logic [48:0]              vbp_prod;
    logic [24:0]              vbp_dec;
    logic [47:0]              extra_prod;
    logic [23:0]              extra_dec;
    logic [24:0]              item_rate;
    logic [24:0]              item_vbp;
    logic [24:0]              item_den;
    side_t                    item_side;
    mom_stat_t                mstat;

    assign in_idx   = s_tdata[ELEM_AW-1:0];
    assign in_grad  = s_tdata[43:12];
    assign in_param = s_tdata[75:44];
    assign in_start = s_tuser[0];

    assign s_tready = adv && !mstat.clearing && !mstat.hazard;
    assign acc      = s_tvalid && s_tready;

    // a pass start sees the new rate and the decayed bias product
    assign rate_start = 25'(final_reg) + 25'(extra_reg);
    assign vbp_prod   = 49'(vbp_reg) * 49'(VAR_DECAY_Q24);
    assign vbp_dec    = vbp_prod[48:24];
    assign extra_prod = 48'(extra_reg) * 48'(rdf_reg);
    assign extra_dec  = extra_prod[47:24];
    assign item_rate  = in_start ? rate_start : prate_reg;
    assign item_vbp   = in_start ? vbp_dec : vbp_reg;
    assign item_den   = ONE_Q24 - item_vbp;

    always_comb
    begin
        item_side.param    = in_param;
        item_side.rate     = item_rate;
        item_side.mom      = '0;
        item_side.den_zero = (item_den == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            md_reg     <= RST_MOMENTUM_DECAY;
            iextra_reg <= RST_EXTRA_RATE;
            final_reg  <= RST_FINAL_RATE;
            rdf_reg    <= RST_RATE_DECAY;
            extra_reg  <= RST_EXTRA_RATE;
            vbp_reg    <= ONE_Q24;
            prate_reg  <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_idx)
                    REG_MOMENTUM_DECAY: md_reg <= pwdata[23:0];
                    REG_INITIAL_EXTRA:
                    begin
                        iextra_reg <= pwdata[23:0];
                        extra_reg  <= pwdata[23:0];   // restarts the schedule
                    end
                    REG_FINAL_RATE:     final_reg <= pwdata[23:0];
                    REG_RATE_DECAY:     rdf_reg   <= pwdata[23:0];
                    default:            md_reg    <= md_reg;
                endcase
            end
            if (acc && in_start)
            begin
                prate_reg <= rate_start;
                extra_reg <= extra_dec;
                vbp_reg   <= vbp_dec;
            end
        end
    end

    // ---------------- moment stores (stages 1-4) ----------------
    logic        mo_valid;
    logic [39:0] mo_sm;
    logic [24:0] mo_den;
    side_t       mo_side;

    amp_moment u_moment (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (adv),
        .in_valid       (acc),
        .in_idx         (in_idx),
        .in_grad        (in_grad),
        .in_den         (item_den),
        .side_in        (item_side),
        .momentum_decay (md_reg),
        .stat           (mstat),
        .out_valid      (mo_valid),
        .out_sm         (mo_sm),
        .out_den        (mo_den),
        .side_out       (mo_side)
    );

    // ---------------- roots of v<<24 and den<<24 ----------------
    logic              sq_valid;
    logic [SQ_RW-1:0]  sq_ra;
    logic [SQ_RW-1:0]  sq_rb;
    side_t             sq_side;

    amp_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (mo_valid),
        .xa        ({mo_sm, 24'b0}),
        .xb        ({15'b0, mo_den, 24'b0}),
        .side_in   (mo_side),
        .out_valid (sq_valid),
        .ra        (sq_ra),
        .rb        (sq_rb),
        .side_out  (sq_side)
    );

    // ---------------- denominator: (s1<<24)/s2 ----------------
    logic              d1_valid;
    logic [DIV_W-1:0]  d1_q;
    side_t             d1_side;

    amp_div u_div_den (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (sq_valid),
        .num       ({8'b0, sq_ra, 24'b0}),
        .dvs       ({32'b0, sq_rb}),
        .side_in   (sq_side),
        .out_valid (d1_valid),
        .quo       (d1_q),
        .side_out  (d1_side)
    );

    // add eps and take |m|<<24 as the next numerator
    logic              bs_valid_reg;
    logic [DIV_W-1:0]  bs_b_reg;
    logic [DIV_W-1:0]  bs_num_reg;
    side_t             bs_side_reg;
    logic [31:0]       mom_abs;

    assign mom_abs = d1_side.mom[31] ? (~d1_side.mom + 32'd1) : d1_side.mom;

    // ---------------- quotient: (|m|<<24)/b ----------------
    logic              d2_valid;
    logic [DIV_W-1:0]  d2_q;
    side_t             d2_side;

    amp_div u_div_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (bs_valid_reg),
        .num       (bs_num_reg),
        .dvs       (bs_b_reg),
        .side_in   (bs_side_reg),
        .out_valid (d2_valid),
        .quo       (d2_q),
        .side_out  (d2_side)
    );

    // clip to +-4, restore the sign (truncation toward zero)
    logic               q_big;
    logic [26:0]        q_mag;
    logic signed [27:0] q_signed;
    logic               cs_valid_reg;
    logic signed [27:0] cs_q_reg;
    logic               cs_clip_reg;
    side_t              cs_side_reg;

    assign q_big    = d2_q > DIV_W'(CLIP_Q24);
    assign q_mag    = q_big ? CLIP_Q24 : d2_q[26:0];
    assign q_signed = d2_side.mom[31] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});

    // scale by the pass rate
    logic               ps_valid_reg;
    logic signed [53:0] ps_prod_reg;
    logic               ps_clip_reg;
    logic signed [31:0] ps_param_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_valid_reg <= 1'b0;
            cs_valid_reg <= 1'b0;
            ps_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            bs_valid_reg <= d1_valid;
            cs_valid_reg <= d2_valid;
            ps_valid_reg <= cs_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bs_b_reg     <= d1_q + EPS_Q24;
            bs_num_reg   <= {8'b0, mom_abs, 24'b0};
            bs_side_reg  <= d1_side;

            // no pass started yet: step is zero, no clip
            cs_q_reg     <= d2_side.den_zero ? '0 : q_signed;
            cs_clip_reg  <= !d2_side.den_zero && q_big;
            cs_side_reg  <= d2_side;

            ps_prod_reg  <= 54'(cs_q_reg) * 54'($signed({1'b0, cs_side_reg.rate}));
            ps_clip_reg  <= cs_clip_reg;
            ps_param_reg <= cs_side_reg.param;
        end
    end

    // add to the parameter, saturate to 32 bits
    logic signed [29:0] step;
    logic signed [32:0] np_wide;
    logic signed [31:0] np_sat;
    logic               push;

    assign step    = ps_prod_reg[53:24];
    assign np_wide = 33'(ps_param_reg) + 33'(step);
    assign np_sat  = (np_wide > 33'sd2147483647)  ? 32'sh7FFFFFFF :
                     (np_wide < -33'sd2147483648) ? 32'sh80000000 : np_wide[31:0];
    assign push    = adv && ps_valid_reg;

    // ---------------- output register plus skid ----------------
    // The pipeline only halts once the skid entry holds a result, so input keeps
    // flowing while a single finished result waits at the output.
    logic               out_v_reg;
    logic [31:0]        out_d_reg;
    logic               out_c_reg;
    logic               sk_v_reg;
    logic [31:0]        sk_d_reg;
    logic               sk_c_reg;
    logic               take;

    assign adv  = !sk_v_reg;
    assign take = out_v_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
            sk_v_reg  <= 1'b0;
        end
        else if (!out_v_reg || take)
        begin
            if (sk_v_reg)
            begin
                out_v_reg <= 1'b1;
                sk_v_reg  <= 1'b0;
            end
            else
            begin
                out_v_reg <= push;
            end
        end
        else if (push)
        begin
            sk_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || take)
        begin
            if (sk_v_reg)
            begin
                out_d_reg <= sk_d_reg;
                out_c_reg <= sk_c_reg;
            end
            else
            begin
                out_d_reg <= np_sat;
                out_c_reg <= ps_clip_reg;
            end
        end
        else if (push)
        begin
            sk_d_reg <= np_sat;
            sk_c_reg <= ps_clip_reg;
        end
    end

    assign m_tvalid   = out_v_reg;
    assign m_tdata    = out_d_reg;
    assign m_tuser[0] = out_c_reg;

endmodule

// ===== hdl/amp_moment.sv =====
// Moment stores with read-modify-write pipeline, index interlock and post-reset clear.
module amp_moment (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [amp_pkg::ELEM_AW-1:0]  in_idx,
    input  logic signed [31:0]           in_grad,
    input  logic [24:0]                  in_den,
    input  amp_pkg::side_t               side_in,
    input  logic [23:0]                  momentum_decay,
    output amp_pkg::mom_stat_t           stat,
    output logic                         out_valid,
    output logic [39:0]                  out_sm,
    output logic [24:0]                  out_den,
    output amp_pkg::side_t               side_out
);
    import amp_pkg::*;

    logic [39:0]        sm_mem [0:ELEMENTS-1];
    logic signed [31:0] fm_mem [0:ELEMENTS-1];

    logic [ELEM_AW:0] clr_cnt_reg;
    logic             clearing;

    logic               s1_valid_reg;
    logic [ELEM_AW-1:0] s1_idx_reg;
    logic signed [31:0] s1_grad_reg;
    logic [24:0]        s1_den_reg;
    side_t              s1_side_reg;
    logic [39:0]        s1_sm_reg;
    logic signed [31:0] s1_fm_reg;

    logic               s2_valid_reg;
    logic [ELEM_AW-1:0] s2_idx_reg;
    logic signed [31:0] s2_grad_reg;
    logic [24:0]        s2_den_reg;
    side_t              s2_side_reg;
    logic [39:0]        s2_sm_reg;
    logic signed [31:0] s2_fm_reg;
    logic [38:0]        s2_g2_reg;

    logic               s3_valid_reg;
    logic [ELEM_AW-1:0] s3_idx_reg;
    logic [24:0]        s3_den_reg;
    side_t              s3_side_reg;
    logic [43:0]        s3_pvh_reg;
    logic [43:0]        s3_pvl_reg;
    logic [40:0]        s3_pgh_reg;
    logic [39:0]        s3_pgl_reg;
    logic signed [56:0] s3_pm1_reg;
    logic signed [57:0] s3_pm2_reg;

    logic               s4_valid_reg;
    logic [39:0]        s4_sm_reg;
    logic [24:0]        s4_den_reg;
    side_t              s4_side_reg;

    logic signed [63:0] gg;
    logic [63:0]        vsum;
    logic signed [57:0] msum;
    logic [39:0]        sm_new;
    logic signed [31:0] fm_new;
    side_t              side_upd;
    logic               mem_we;
    logic [ELEM_AW-1:0] mem_wa;
    logic [24:0]        md_comp;

    assign clearing = !clr_cnt_reg[ELEM_AW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (clearing)
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
    end

    // an item may not read an index whose update is still in flight
    assign stat.clearing = clearing;
    assign stat.hazard   = (s1_valid_reg && s1_idx_reg == in_idx)
                        || (s2_valid_reg && s2_idx_reg == in_idx)
                        || (s3_valid_reg && s3_idx_reg == in_idx);

    assign gg      = 64'(in_grad) * 64'(in_grad);
    assign md_comp = ONE_Q24 - {1'b0, momentum_decay};

    assign vsum = (64'(s3_pvh_reg) << 20) + 64'(s3_pvl_reg)
                + (64'(s3_pgh_reg) << 19) + 64'(s3_pgl_reg);
    assign msum = 58'(s3_pm1_reg) + s3_pm2_reg;
    assign sm_new = vsum[63:24];
    assign fm_new = msum[55:24];

    always_comb
    begin
        side_upd     = s3_side_reg;
        side_upd.mom = fm_new;
    end

    assign mem_we = clearing || (en && s3_valid_reg);
    assign mem_wa = clearing ? clr_cnt_reg[ELEM_AW-1:0] : s3_idx_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            sm_mem[mem_wa] <= clearing ? '0 : sm_new;
            fm_mem[mem_wa] <= clearing ? '0 : fm_new;
        end
        if (en)
        begin
            s1_sm_reg <= sm_mem[in_idx];
            s1_fm_reg <= fm_mem[in_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_idx_reg  <= in_idx;
            s1_grad_reg <= in_grad;
            s1_den_reg  <= in_den;
            s1_side_reg <= side_in;

            s2_idx_reg  <= s1_idx_reg;
            s2_grad_reg <= s1_grad_reg;
            s2_den_reg  <= s1_den_reg;
            s2_side_reg <= s1_side_reg;
            s2_sm_reg   <= s1_sm_reg;
            s2_fm_reg   <= s1_fm_reg;
            // full-scale negative gradient squares to 2^38: needs 39 bits
            s2_g2_reg   <= 39'(64'(64'(s1_grad_reg) * 64'(s1_grad_reg)) >> 24);

            s3_idx_reg  <= s2_idx_reg;
            s3_den_reg  <= s2_den_reg;
            s3_side_reg <= s2_side_reg;
            s3_pvh_reg  <= 44'(s2_sm_reg[39:20]) * 44'(VAR_DECAY_Q24);
            s3_pvl_reg  <= 44'(s2_sm_reg[19:0]) * 44'(VAR_DECAY_Q24);
            s3_pgh_reg  <= 41'(s2_g2_reg[38:19]) * 41'(VAR_GAIN_Q24);
            s3_pgl_reg  <= 40'(s2_g2_reg[18:0]) * 40'(VAR_GAIN_Q24);
            s3_pm1_reg  <= 57'($signed({1'b0, momentum_decay})) * 57'(s2_fm_reg);
            s3_pm2_reg  <= 58'($signed({1'b0, md_comp})) * 58'(s2_grad_reg);

            s4_sm_reg   <= sm_new;
            s4_den_reg  <= s3_den_reg;
            s4_side_reg <= side_upd;
        end
    end

    assign out_valid = s4_valid_reg;
    assign out_sm    = s4_sm_reg;
    assign out_den   = s4_den_reg;
    assign side_out  = s4_side_reg;

    // gg only feeds the unused upper check below; keeps the square sign-safe
    a_sq_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> !gg[63])
        else $error("gradient square negative");

    a_idx_12: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg) |-> (s1_idx_reg != s2_idx_reg))
        else $error("same index in adjacent update stages");

    a_idx_23: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && s3_valid_reg) |-> (s2_idx_reg != s3_idx_reg))
        else $error("same index in adjacent update stages");

    a_idx_13: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s3_valid_reg) |-> (s1_idx_reg != s3_idx_reg))
        else $error("same index twice in update window");

    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !(s1_valid_reg || s2_valid_reg || s3_valid_reg || s4_valid_reg))
        else $error("item in flight during store clear");

endmodule

// ===== hdl/amp_sqrt.sv =====
// Two-lane pipelined integer square root, SQ_STEP root bits per stage.
module amp_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [amp_pkg::SQ_XW-1:0]    xa,
    input  logic [amp_pkg::SQ_XW-1:0]    xb,
    input  amp_pkg::side_t               side_in,
    output logic                         out_valid,
    output logic [amp_pkg::SQ_RW-1:0]    ra,
    output logic [amp_pkg::SQ_RW-1:0]    rb,
    output amp_pkg::side_t               side_out
);
    import amp_pkg::*;

    logic [SQ_XW-1:0] rem_a_reg [0:SQ_STAGES-1];
    logic [SQ_XW-1:0] rem_b_reg [0:SQ_STAGES-1];
    logic [SQ_RW-1:0] rt_a_reg  [0:SQ_STAGES-1];
    logic [SQ_RW-1:0] rt_b_reg  [0:SQ_STAGES-1];
    side_t            side_reg  [0:SQ_STAGES-1];
    logic             vld_reg   [0:SQ_STAGES-1];

    for (genvar k = 0; k < SQ_STAGES; k++)
    begin : g_st
        logic [SQ_XW-1:0] rem_a_in, rem_b_in, rem_a_next, rem_b_next, trial_a, trial_b;
        logic [SQ_RW-1:0] rt_a_in, rt_b_in, rt_a_next, rt_b_next;
        side_t            side_k;
        logic             vld_k;

        if (k == 0)
        begin : g_first
            assign rem_a_in = xa;
            assign rem_b_in = xb;
            assign rt_a_in  = '0;
            assign rt_b_in  = '0;
            assign side_k   = side_in;
            assign vld_k    = in_valid;
        end
        else
        begin : g_rest
            assign rem_a_in = rem_a_reg[k-1];
            assign rem_b_in = rem_b_reg[k-1];
            assign rt_a_in  = rt_a_reg[k-1];
            assign rt_b_in  = rt_b_reg[k-1];
            assign side_k   = side_reg[k-1];
            assign vld_k    = vld_reg[k-1];
        end

        // trial = (root + 2^b)^2 - root^2
        always_comb
        begin
            rem_a_next = rem_a_in;
            rem_b_next = rem_b_in;
            rt_a_next  = rt_a_in;
            rt_b_next  = rt_b_in;
            trial_a    = '0;
            trial_b    = '0;
            for (int j = 0; j < SQ_STEP; j++)
            begin
                trial_a = (SQ_XW'(rt_a_next) << (SQ_RW - k*SQ_STEP - j))
                        | (SQ_XW'(1) << (2*(SQ_RW - 1 - k*SQ_STEP - j)));
                trial_b = (SQ_XW'(rt_b_next) << (SQ_RW - k*SQ_STEP - j))
                        | (SQ_XW'(1) << (2*(SQ_RW - 1 - k*SQ_STEP - j)));
                if (rem_a_next >= trial_a)
                begin
                    rem_a_next = rem_a_next - trial_a;
                    rt_a_next  = rt_a_next | (SQ_RW'(1) << (SQ_RW - 1 - k*SQ_STEP - j));
                end
                if (rem_b_next >= trial_b)
                begin
                    rem_b_next = rem_b_next - trial_b;
                    rt_b_next  = rt_b_next | (SQ_RW'(1) << (SQ_RW - 1 - k*SQ_STEP - j));
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_k;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_a_reg[k] <= rem_a_next;
                rem_b_reg[k] <= rem_b_next;
                rt_a_reg[k]  <= rt_a_next;
                rt_b_reg[k]  <= rt_b_next;
                side_reg[k]  <= side_k;
            end
        end
    end

    assign out_valid = vld_reg[SQ_STAGES-1];
    assign ra        = rt_a_reg[SQ_STAGES-1];
    assign rb        = rt_b_reg[SQ_STAGES-1];
    assign side_out  = side_reg[SQ_STAGES-1];

endmodule

// ===== hdl/amp_div.sv =====
// Pipelined unsigned restoring divider, DIV_STEP quotient bits per stage.
module amp_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [amp_pkg::DIV_W-1:0]    num,
    input  logic [amp_pkg::DIV_W-1:0]    dvs,
    input  amp_pkg::side_t               side_in,
    output logic                         out_valid,
    output logic [amp_pkg::DIV_W-1:0]    quo,
    output amp_pkg::side_t               side_out
);
    import amp_pkg::*;

    logic [DIV_W:0]   rem_reg  [0:DIV_STAGES-1];
    logic [DIV_W-1:0] num_reg  [0:DIV_STAGES-1];
    logic [DIV_W-1:0] quo_reg  [0:DIV_STAGES-1];
    logic [DIV_W-1:0] dvs_reg  [0:DIV_STAGES-1];
    side_t            side_reg [0:DIV_STAGES-1];
    logic             vld_reg  [0:DIV_STAGES-1];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_st
        logic [DIV_W:0]   rem_in, rem_next;
        logic [DIV_W-1:0] num_in, num_next, quo_in, quo_next, dvs_in;
        side_t            side_k;
        logic             vld_k;

        if (k == 0)
        begin : g_first
            assign rem_in = '0;
            assign num_in = num;
            assign quo_in = '0;
            assign dvs_in = dvs;
            assign side_k = side_in;
            assign vld_k  = in_valid;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign num_in = num_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign dvs_in = dvs_reg[k-1];
            assign side_k = side_reg[k-1];
            assign vld_k  = vld_reg[k-1];
        end

        always_comb
        begin
            rem_next = rem_in;
            num_next = num_in;
            quo_next = quo_in;
            for (int j = 0; j < DIV_STEP; j++)
            begin
                rem_next = {rem_next[DIV_W-1:0], num_next[DIV_W-1]};
                num_next = num_next << 1;
                if (rem_next >= {1'b0, dvs_in})
                begin
                    rem_next = rem_next - {1'b0, dvs_in};
                    quo_next = {quo_next[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_next[DIV_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (en)
                vld_reg[k] <= vld_k;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                num_reg[k]  <= num_next;
                quo_reg[k]  <= quo_next;
                dvs_reg[k]  <= dvs_in;
                side_reg[k] <= side_k;
            end
        end
    end

    assign out_valid = vld_reg[DIV_STAGES-1];
    assign quo       = quo_reg[DIV_STAGES-1];
    assign side_out  = side_reg[DIV_STAGES-1];

endmodule

// ===== bench/adaptive_moment_param_update_top_test.sv =====
// Self-checking bench for the adaptive-moment parameter update engine.
module adaptive_moment_param_update_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import amp_pkg::*;

    localparam logic [63:0] MASK24    = 64'hFFFFFF;
    localparam logic [63:0] MASK40    = 64'hFF_FFFF_FFFF;
    localparam int          WDOG_MAX  = 20000;   // covers the post-reset store clear
    localparam int          DRAIN_CYC = 120;     // more than the pipeline latency
    localparam int          HOLD_LEN  = 400;     // long receiver hold-off

    // idle modes: sender / receiver off percentage
    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [11:0]        idx;
        logic signed [31:0] grad;
        logic signed [31:0] param;
        logic               start;
        logic               typed;   // expectation written in the row
        logic signed [31:0] np;
        logic               clip;
    } stim_row_t;

    typedef struct {
        logic               typed;
        logic signed [31:0] np;
        logic               clip;
    } typed_exp_t;

    typedef struct {
        logic signed [31:0] np;
        logic               clip;
    } update_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    adaptive_moment_param_update_top uut (.*);

    always #5 clk = ~clk;

    // ---------------------------------------------------------------
    // Predictor state: moment stores, pass schedule and registers
    // ---------------------------------------------------------------
    logic [63:0] sq_grad_avg [ELEMENTS];
    int          mom_avg [ELEMENTS];
    logic [63:0] var_bias, extra_rt, pass_rt;
    logic [63:0] cfg_md, cfg_init_extra, cfg_final, cfg_rdf;

    update_t    expected_updates[$];
    typed_exp_t row_expects[$];

    idle_mode_t idle_mode = IDLE_NONE;
    logic       hold_req = 1'b0;     // toggled to request a long hold-off
    logic       hold_seen = 1'b0;
    int         hold_cycles = 0;
    int         fails = 0;
    int         quiet_cycles = 0;

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'h1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    task automatic reset_model();
        foreach (sq_grad_avg[i]) begin
            sq_grad_avg[i] = '0;
            mom_avg[i] = 0;
        end
        cfg_md = 64'(RST_MOMENTUM_DECAY);
        cfg_init_extra = 64'(RST_EXTRA_RATE);
        cfg_final = 64'(RST_FINAL_RATE);
        cfg_rdf = 64'(RST_RATE_DECAY);
        var_bias = 64'(ONE_Q24);
        extra_rt = cfg_init_extra;
        pass_rt = '0;
    endtask

    // one element update: advances the stores and returns the new parameter
    task automatic update_element(input logic [11:0] idx, input logic signed [31:0] grad,
                                  input logic signed [31:0] param, input logic start,
                                  output update_t res);
        longint      g, m, q, b, step, np;
        logic [63:0] g2, v, den, s1, s2;
        g = longint'(grad);
        q = 0;
        res.clip = 1'b0;
        if (start) begin
            pass_rt = cfg_final + extra_rt;
            extra_rt = ((extra_rt * cfg_rdf) >> 24) & MASK24;
            var_bias = (var_bias * 64'(VAR_DECAY_Q24)) >> 24;
        end
        g2 = 64'(g * g) >> 24;
        v = ((sq_grad_avg[idx] * 64'(VAR_DECAY_Q24) + g2 * 64'(VAR_GAIN_Q24)) >> 24) & MASK40;
        sq_grad_avg[idx] = v;
        m = (longint'(cfg_md) * longint'(mom_avg[idx])
             + longint'(64'(ONE_Q24) - cfg_md) * g) >>> 24;
        mom_avg[idx] = int'(m);
        den = 64'(ONE_Q24) - var_bias;
        if (den != 0) begin
            s1 = int_sqrt(v << 24);
            s2 = int_sqrt(den << 24);
            b = longint'((s1 << 24) / s2) + 168;
            q = (m * 64'sd16777216) / b;
            if (q > 64'sd67108864) begin
                q = 64'sd67108864;
                res.clip = 1'b1;
            end else if (q < -64'sd67108864) begin
                q = -64'sd67108864;
                res.clip = 1'b1;
            end
        end
        step = (q * longint'(pass_rt)) >>> 24;
        np = longint'(param) + step;
        if (np > 64'sd2147483647)
            np = 64'sd2147483647;
        if (np < -64'sd2147483648)
            np = -64'sd2147483648;
        res.np = np[31:0];
    endtask

    // ---------------------------------------------------------------
    // Input monitor: every accepted transfer feeds the predictor
    // ---------------------------------------------------------------
    always @(posedge clk) begin
        update_t    res;
        typed_exp_t te;
        if (rst_n && s_tvalid && s_tready) begin
            update_element(s_tdata[11:0], s_tdata[43:12], s_tdata[75:44], s_tuser[0], res);
            te = row_expects.pop_front();
            if (te.typed) begin
                // table rows with an expectation typed in override the predictor
                res.np = te.np;
                res.clip = te.clip;
            end
            expected_updates.push_back(res);
        end
    end

    // Output monitor: compare each result against the oldest expectation
    always @(posedge clk) begin
        update_t e;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_updates.size() == 0) begin
                $error("unexpected result new_param=%0d", $signed(m_tdata));
                fails++;
            end else begin
                e = expected_updates.pop_front();
                if (m_tdata !== e.np) begin
                    $error("new_param expected %0d actual %0d", e.np, $signed(m_tdata));
                    fails++;
                end
                if (m_tuser[0] !== e.clip) begin
                    $error("step_clipped expected %0d actual %0d", e.clip, m_tuser[0]);
                    fails++;
                end
            end
        end
    end

    // Receiver: random stalls per idle mode, plus the long hold-off window
    always @(posedge clk) begin
        int pct;
        pct = (idle_mode == IDLE_RECV) ? 70 : (idle_mode == IDLE_BOTH) ? 24 : 0;
        if (hold_cycles > 0)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= pct);
    end

    // hold-off counter: a toggle of hold_req loads a fresh window
    always @(posedge clk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_cycles <= HOLD_LEN;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end
    end

    // Watchdog: any transfer on either stream or the config port resets it
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_MAX) begin
            $display("[adaptive_moment_param_update_top] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    task automatic cfg_write(input reg_idx_t r, input logic [23:0] val);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 4'(r) << 2;
        pwdata <= {8'h0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);    // register taken at this edge
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (r)
            REG_MOMENTUM_DECAY: cfg_md = 64'(val);
            REG_INITIAL_EXTRA:
            begin
                cfg_init_extra = 64'(val);
                extra_rt = 64'(val);    // schedule restarts
            end
            REG_FINAL_RATE:     cfg_final = 64'(val);
            default:            cfg_rdf = 64'(val);
        endcase
    endtask

    task automatic send_item(input stim_row_t row);
        typed_exp_t te;
        int pct;
        pct = (idle_mode == IDLE_SEND) ? 70 : (idle_mode == IDLE_BOTH) ? 24 : 0;
        if ($urandom_range(99) < pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        te.typed = row.typed;
        te.np = row.np;
        te.clip = row.clip;
        row_expects.push_back(te);
        s_tdata <= {4'h0, row.param, row.grad, row.idx};
        s_tuser <= row.start;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic end_stream();
        s_tvalid <= 1'b0;
    endtask

    // wait for every expected update, then let the pipeline settle
    task automatic drain();
        end_stream();
        while (expected_updates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    function automatic stim_row_t random_row(input int pass_pct);
        stim_row_t r;
        r.typed = 1'b0;
        r.np = '0;
        r.clip = 1'b0;
        // mostly a small pool of elements so the moments build up over passes
        r.idx = ($urandom_range(3) == 0) ? 12'($urandom) : 12'($urandom_range(15));
        case ($urandom_range(3))
            0: r.grad = $urandom;
            1: r.grad = 32'sd0 + $signed(32'($urandom_range(16383))) - 32'sd8192;
            2: r.grad = $signed($urandom) >>> $urandom_range(24);
            default: r.grad = $signed(32'($urandom_range(65535))) - 32'sd32768;
        endcase
        case ($urandom_range(3))
            0: r.param = 32'h7FFF_FFFF - 32'($urandom_range(1 << 26));
            1: r.param = 32'h8000_0000 + 32'($urandom_range(1 << 26));
            default: r.param = $urandom;
        endcase
        r.start = ($urandom_range(99) < pass_pct);
        return r;
    endfunction

    task automatic random_phase(input idle_mode_t mode, input int count);
        idle_mode = mode;
        repeat (count)
            send_item(random_row(5));
        drain();
    endtask

    // directed rows: before the first pass the step is zero, so the
    // parameter passes through untouched and no clip is flagged
    stim_row_t dir_rows[] = '{
        '{12'd0,    32'sh0000_0000, 32'sh0000_0000, 1'b0, 1'b1, 32'sh0000_0000, 1'b0},
        '{12'd4095, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 1'b1, 32'sh7FFF_FFFF, 1'b0},
        '{12'd1,    32'sh8000_0000, 32'sh8000_0000, 1'b0, 1'b1, 32'sh8000_0000, 1'b0},
        '{12'd2,    32'shFFFF_FFFF, 32'shFFFF_FFFF, 1'b0, 1'b1, 32'shFFFF_FFFF, 1'b0},
        '{12'd3,    32'sh0000_0001, 32'sh5555_5555, 1'b0, 1'b1, 32'sh5555_5555, 1'b0},
        '{12'd4,    32'shAAAA_AAAA, 32'shAAAA_AAAA, 1'b0, 1'b1, 32'shAAAA_AAAA, 1'b0},
        // first pass: tiny gradient on fresh elements drives the clip both ways
        '{12'd10,   32'sh0000_2000, 32'sh0000_0000, 1'b1, 1'b0, 32'sh0, 1'b0},
        '{12'd11,   32'shFFFF_E000, 32'sh0000_0000, 1'b0, 1'b0, 32'sh0, 1'b0},
        '{12'd0,    32'sh0100_0000, 32'sh0100_0000, 1'b0, 1'b0, 32'sh0, 1'b0},
        '{12'd4095, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 1'b0, 32'sh0, 1'b0},
        '{12'd1,    32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, 1'b0, 32'sh0, 1'b0},
        '{12'd12,   32'sh0000_0000, 32'sh1234_5678, 1'b0, 1'b0, 32'sh0, 1'b0},
        '{12'd10,   32'sh0000_2000, 32'sh0000_0000, 1'b1, 1'b0, 32'sh0, 1'b0},
        '{12'd10,   32'shFFFF_E000, 32'sh7FFF_FF00, 1'b0, 1'b0, 32'sh0, 1'b0},
        '{12'd2,    32'shF000_0000, 32'sh8000_0100, 1'b1, 1'b0, 32'sh0, 1'b0},
        '{12'd2048, 32'sh0FFF_FFFF, 32'shFFFF_FFFF, 1'b0, 1'b0, 32'sh0, 1'b0}
    };

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        reset_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed table with reset register values
        foreach (dir_rows[i])
            send_item(dir_rows[i]);
        drain();

        // default registers, no idling
        random_phase(IDLE_NONE, 150);

        // lowest decays and fastest rates: large steps, saturation
        cfg_write(REG_MOMENTUM_DECAY, 24'h000000);
        cfg_write(REG_INITIAL_EXTRA, 24'hFFFFFF);
        cfg_write(REG_FINAL_RATE, 24'hFFFFFF);
        cfg_write(REG_RATE_DECAY, 24'h000000);
        random_phase(IDLE_SEND, 200);

        // receiver holds off long while the sender keeps offering
        idle_mode = IDLE_NONE;
        hold_req = ~hold_req;
        repeat (150)
            send_item(random_row(5));
        drain();

        // top decays, no extra rate
        cfg_write(REG_MOMENTUM_DECAY, 24'hFFFFFF);
        cfg_write(REG_INITIAL_EXTRA, 24'h000000);
        cfg_write(REG_FINAL_RATE, 24'h000000);
        cfg_write(REG_RATE_DECAY, 24'hFFFFFF);
        random_phase(IDLE_RECV, 150);

        // random mid-range settings
        cfg_write(REG_MOMENTUM_DECAY, 24'($urandom));
        cfg_write(REG_INITIAL_EXTRA, 24'($urandom));
        cfg_write(REG_FINAL_RATE, 24'($urandom_range(1 << 22)));
        cfg_write(REG_RATE_DECAY, 24'($urandom));
        random_phase(IDLE_BOTH, 200);

        // back to the reset values with the schedule restarted
        cfg_write(REG_MOMENTUM_DECAY, RST_MOMENTUM_DECAY);
        cfg_write(REG_INITIAL_EXTRA, RST_EXTRA_RATE);
        cfg_write(REG_FINAL_RATE, RST_FINAL_RATE);
        cfg_write(REG_RATE_DECAY, RST_RATE_DECAY);
        random_phase(IDLE_NONE, 150);

        if (fails == 0 && expected_updates.size() == 0)
            $display("[adaptive_moment_param_update_top] OK");
        else
            $display("[adaptive_moment_param_update_top] ERROR");
        $finish;
    end

endmodule
